// ===== hw/rtl/particle_wall_rebound_unit_macros.svh =====
// Assertion macros for the wall rebound unit.
// Every use sits inside a module that has clk and rst_n.
`ifndef PARTICLE_WALL_REBOUND_UNIT_MACROS_SVH
`define PARTICLE_WALL_REBOUND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, quiet during reset
`define PWR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rebound unit check failed");
// Next-cycle implication, quiet during reset
`define PWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rebound unit check failed");
`else
`define PWR_ASSERT_IMPL(lbl, ante, cons)
`define PWR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/pwr_pkg.sv =====
package pwr_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION    = 2'd1;

  // Coefficients are unsigned Q1.16 with 1.0 as the top value
  localparam int unsigned COEF_W = 17;
  localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

  typedef struct packed {
    logic signed [31:0] area_x;
    logic signed [31:0] area_y;
    logic signed [31:0] area_z;
    logic signed [31:0] mean_vx;
    logic signed [31:0] mean_vy;
    logic signed [31:0] mean_vz;
    logic signed [31:0] fluct_vx;
    logic signed [31:0] fluct_vy;
    logic signed [31:0] fluct_vz;
  } pwr_in_t;

  typedef struct packed {
    logic signed [31:0] new_fluct_vx;
    logic signed [31:0] new_fluct_vy;
    logic signed [31:0] new_fluct_vz;
    logic               degenerate_normal;
  } pwr_out_t;

  // Word that travels down the cell chain; each stage fills its own fields
  typedef struct packed {
    logic [2:0]        neg;    // sign of each area component
    logic              deg;    // zero area vector
    logic [31:0]       mx;     // largest area magnitude
    logic [2:0][31:0]  am;     // area magnitudes, normalized later
    logic [2:0][32:0]  u;      // total velocity, signed
    logic [2:0][31:0]  mean;   // mean velocity, signed
    logic [2:0][63:0]  sq;     // squared magnitudes
    logic [63:0]       sx;     // root radicand, consumed two bits a step
    logic [35:0]       srem;   // root partial remainder
    logic [31:0]       sroot;  // root partial result
    logic [31:0]       m;      // floor root of the squared length
    logic [2:0][31:0]  drem;   // divider partial remainders
    logic [2:0][30:0]  dbits;  // dividend bits still to bring down
    logic [2:0][30:0]  dq;     // quotient magnitudes
    logic [2:0][31:0]  nrm;    // unit normal, signed Q2.30
    logic [2:0][68:0]  prod;   // product scratch, signed
    logic [68:0]       dot;    // velocity dot normal, signed
    logic [36:0]       un;     // normal speed, signed Q21.16
    logic [2:0][38:0]  vn;     // normal part, signed
    logic [2:0][57:0]  rc;     // reflection product, signed
    logic [2:0][58:0]  fc;     // friction product, signed
    logic [2:0][41:0]  r1;     // rounded reflection term, signed
    logic [2:0][42:0]  r2;     // rounded friction term, signed
  } pwr_sb_t;

  // Round v / 2^sh to nearest, ties away from zero; v and result two's complement
  function automatic logic [71:0] rnd_sh(input logic [71:0] v, input int unsigned sh);
    logic [71:0] mag;
    logic [71:0] r;
    mag = v[71] ? (72'd0 - v) : v;
    r   = (mag + (72'd1 << (sh - 1))) >> sh;
    return v[71] ? (72'd0 - r) : r;
  endfunction

  // Clamp a coefficient to 1.0
  function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] v);
    return (v > COEF_ONE) ? COEF_ONE : v;
  endfunction

endpackage

// ===== hw/rtl/pwr_norm_cell.sv =====
module pwr_norm_cell
  import pwr_pkg::*;
#(
  parameter int unsigned SHIFT = 16
) (
  input  logic    clk,
  input  logic    en,
  input  pwr_sb_t sb_i,
  output pwr_sb_t sb_o
);

  pwr_sb_t sb_r;
  pwr_sb_t sb_nxt;

  // Shift all magnitudes by SHIFT if the largest stays below 2^31
  always_comb begin
    sb_nxt = sb_i;
    if (!sb_i.mx[31] && (sb_i.mx[30 -: SHIFT] == '0)) begin
      sb_nxt.mx = sb_i.mx << SHIFT;
      for (int i = 0; i < 3; i++) begin
        sb_nxt.am[i] = sb_i.am[i] << SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= sb_nxt;
    end
  end

  assign sb_o = sb_r;

endmodule

// ===== hw/rtl/pwr_sqrt_cell.sv =====
module pwr_sqrt_cell
  import pwr_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  pwr_sb_t sb_i,
  output pwr_sb_t sb_o
);

  pwr_sb_t     sb_r;
  pwr_sb_t     sb_nxt;
  logic [35:0] rem2;
  logic [35:0] trial;

  // One root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    sb_nxt = sb_i;
    rem2   = {sb_i.srem[33:0], sb_i.sx[63:62]};
    trial  = {2'b00, sb_i.sroot, 2'b01};
    sb_nxt.sx = sb_i.sx << 2;
    if (rem2 >= trial) begin
      sb_nxt.srem  = rem2 - trial;
      sb_nxt.sroot = {sb_i.sroot[30:0], 1'b1};
    end else begin
      sb_nxt.srem  = rem2;
      sb_nxt.sroot = {sb_i.sroot[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= sb_nxt;
    end
  end

  assign sb_o = sb_r;

endmodule

// ===== hw/rtl/pwr_div_cell.sv =====
module pwr_div_cell
  import pwr_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  pwr_sb_t sb_i,
  output pwr_sb_t sb_o
);

  pwr_sb_t     sb_r;
  pwr_sb_t     sb_nxt;
  logic [32:0] t [3];

  // One quotient bit per lane, all lanes share the root as divisor
  always_comb begin
    sb_nxt = sb_i;
    for (int i = 0; i < 3; i++) begin
      t[i] = {sb_i.drem[i], sb_i.dbits[i][30]};
      sb_nxt.dbits[i] = sb_i.dbits[i] << 1;
      if (t[i] >= {1'b0, sb_i.m}) begin
        sb_nxt.drem[i] = 32'(t[i] - {1'b0, sb_i.m});
        sb_nxt.dq[i]   = {sb_i.dq[i][29:0], 1'b1};
      end else begin
        sb_nxt.drem[i] = t[i][31:0];
        sb_nxt.dq[i]   = {sb_i.dq[i][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= sb_nxt;
    end
  end

  assign sb_o = sb_r;

endmodule

// ===== hw/rtl/particle_wall_rebound_unit.sv =====
// Channel   Direction  Beat contents
// in_       input      area, mean and fluctuating velocity vectors (pwr_in_t)
// out_      output     new fluctuating velocity and degenerate flag (pwr_out_t)
// cfg_      input      register index and 17-bit coefficient, always ready
//
// One beat enters per cycle while the chain is not held; the chain has 82
// register stages, from the input capture through the output register.
// Most of them are the 32-step square root chain and the 31-step
// divider chain that turn the area vector into the unit normal.
// The whole chain advances together; it holds only while a result waits.
// Synchronous reset clears the valid chain and restores both coefficients.
`include "particle_wall_rebound_unit_macros.svh"

module particle_wall_rebound_unit
  import pwr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pwr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int unsigned NORM_N   = 5;
  localparam int unsigned SQRT_N   = 32;
  localparam int unsigned DIV_N    = 31;
  localparam int unsigned POST_N   = 8;
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_MX    = 1;
  localparam int unsigned ST_NRM0  = 2;
  localparam int unsigned ST_SQ    = ST_NRM0 + NORM_N;
  localparam int unsigned ST_SQI   = ST_SQ + 1;
  localparam int unsigned ST_SQRT0 = ST_SQI + 1;
  localparam int unsigned ST_DVI   = ST_SQRT0 + SQRT_N;
  localparam int unsigned ST_DIV0  = ST_DVI + 1;
  localparam int unsigned ST_P0    = ST_DIV0 + DIV_N;
  localparam int unsigned ST_OUT   = ST_P0 + POST_N;
  localparam int unsigned NST      = ST_OUT + 1;
  localparam int unsigned NCHAIN   = ST_P0;

  localparam logic signed [45:0] SAT_HI = 46'sh0000_7FFF_FFFF;
  localparam logic signed [45:0] SAT_LO = -46'sh0000_8000_0000;

  logic                en;
  logic [NST-1:0]      vld_r;
  logic [COEF_W-1:0]   res_r;
  logic [COEF_W-1:0]   fric_r;
  pwr_sb_t             sb_w [NCHAIN];
  pwr_sb_t             in_st_r, in_st_nxt;
  pwr_sb_t             mx_st_r, mx_st_nxt;
  pwr_sb_t             sq_st_r, sq_st_nxt;
  pwr_sb_t             sqi_st_r, sqi_st_nxt;
  pwr_sb_t             dvi_st_r, dvi_st_nxt;
  pwr_sb_t             post_r [POST_N];
  pwr_sb_t             post_nxt [POST_N];
  pwr_out_t            out_r, out_nxt;
  logic [31:0]         a_in [3];
  logic [31:0]         m_in [3];
  logic [31:0]         f_in [3];
  logic [61:0]         num [3];
  logic signed [39:0]  vt [3];
  logic [COEF_W:0]     rsum;
  logic signed [45:0]  vs [3];
  logic [32:0]         fl [3];
  logic [31:0]         res_v [3];
  logic                quot_ok;

  // Advance the whole chain unless a finished result is held
  assign en        = !vld_r[ST_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Take coefficient writes, clamped to 1.0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= COEF_ONE;
      fric_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESTITUTION: res_r  <= sat_coef(cfg_data);
        CFG_FRICTION:    fric_r <= sat_coef(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture the beat: magnitudes, signs, total velocity
  always_comb begin
    a_in[0] = in_data.area_x;
    a_in[1] = in_data.area_y;
    a_in[2] = in_data.area_z;
    m_in[0] = in_data.mean_vx;
    m_in[1] = in_data.mean_vy;
    m_in[2] = in_data.mean_vz;
    f_in[0] = in_data.fluct_vx;
    f_in[1] = in_data.fluct_vy;
    f_in[2] = in_data.fluct_vz;
    in_st_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      in_st_nxt.neg[i]  = a_in[i][31];
      in_st_nxt.am[i]   = a_in[i][31] ? (32'd0 - a_in[i]) : a_in[i];
      in_st_nxt.u[i]    = 33'($signed(m_in[i])) + 33'($signed(f_in[i]));
      in_st_nxt.mean[i] = m_in[i];
    end
  end

  // Find the largest magnitude and flag a zero area vector
  always_comb begin
    mx_st_nxt = in_st_r;
    mx_st_nxt.mx = in_st_r.am[0];
    if (in_st_r.am[1] > mx_st_nxt.mx) begin
      mx_st_nxt.mx = in_st_r.am[1];
    end
    if (in_st_r.am[2] > mx_st_nxt.mx) begin
      mx_st_nxt.mx = in_st_r.am[2];
    end
    mx_st_nxt.deg = (mx_st_nxt.mx == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_st_r <= in_st_nxt;
      mx_st_r <= mx_st_nxt;
    end
  end

  assign sb_w[ST_IN] = in_st_r;
  assign sb_w[ST_MX] = mx_st_r;

  // Normalizing shift: steps of 16, 8, 4, 2, 1
  for (genvar k = 0; k < NORM_N; k++) begin : g_norm
    pwr_norm_cell #(.SHIFT(16 >> k)) u_norm (
      .clk  (clk),
      .en   (en),
      .sb_i (sb_w[ST_NRM0 + k - 1]),
      .sb_o (sb_w[ST_NRM0 + k])
    );
  end

  // Square each magnitude, then sum into the root radicand
  always_comb begin
    sq_st_nxt = sb_w[ST_SQ - 1];
    for (int i = 0; i < 3; i++) begin
      sq_st_nxt.sq[i] = 64'(sb_w[ST_SQ - 1].am[i]) * 64'(sb_w[ST_SQ - 1].am[i]);
    end
    sqi_st_nxt       = sq_st_r;
    sqi_st_nxt.sx    = sq_st_r.sq[0] + sq_st_r.sq[1] + sq_st_r.sq[2];
    sqi_st_nxt.srem  = '0;
    sqi_st_nxt.sroot = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_st_r  <= sq_st_nxt;
      sqi_st_r <= sqi_st_nxt;
    end
  end

  assign sb_w[ST_SQ]  = sq_st_r;
  assign sb_w[ST_SQI] = sqi_st_r;

  // Square root, one result bit per cell
  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    pwr_sqrt_cell u_sqrt (
      .clk  (clk),
      .en   (en),
      .sb_i (sb_w[ST_SQRT0 + k - 1]),
      .sb_o (sb_w[ST_SQRT0 + k])
    );
  end

  // Load dividers with magnitude * 2^30 plus half the root
  always_comb begin
    dvi_st_nxt   = sb_w[ST_DVI - 1];
    dvi_st_nxt.m = sb_w[ST_DVI - 1].sroot;
    for (int i = 0; i < 3; i++) begin
      num[i] = {sb_w[ST_DVI - 1].am[i], 30'd0} + 62'(sb_w[ST_DVI - 1].sroot[31:1]);
      dvi_st_nxt.drem[i]  = {1'b0, num[i][61:31]};
      dvi_st_nxt.dbits[i] = num[i][30:0];
      dvi_st_nxt.dq[i]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvi_st_r <= dvi_st_nxt;
    end
  end

  assign sb_w[ST_DVI] = dvi_st_r;

  // Divide, one quotient bit per cell
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    pwr_div_cell u_div (
      .clk  (clk),
      .en   (en),
      .sb_i (sb_w[ST_DIV0 + k - 1]),
      .sb_o (sb_w[ST_DIV0 + k])
    );
  end

  // Projection, reflection and friction
  always_comb begin
    rsum = {1'b0, COEF_ONE} + {1'b0, res_r};

    // Apply signs to the normal
    post_nxt[0] = sb_w[NCHAIN - 1];
    for (int i = 0; i < 3; i++) begin
      post_nxt[0].nrm[i] = sb_w[NCHAIN - 1].neg[i] ? (32'd0 - 32'(sb_w[NCHAIN - 1].dq[i]))
                                                   : 32'(sb_w[NCHAIN - 1].dq[i]);
    end

    // Velocity times normal
    post_nxt[1] = post_r[0];
    for (int i = 0; i < 3; i++) begin
      post_nxt[1].prod[i] = 69'($signed(post_r[0].u[i])) * 69'($signed(post_r[0].nrm[i]));
    end

    // Sum the dot product
    post_nxt[2] = post_r[1];
    post_nxt[2].dot = 69'($signed(post_r[1].prod[0]) + $signed(post_r[1].prod[1])
                          + $signed(post_r[1].prod[2]));

    // Round to the normal speed
    post_nxt[3] = post_r[2];
    post_nxt[3].un = 37'(rnd_sh(72'($signed(post_r[2].dot)), 30));

    // Normal speed times normal
    post_nxt[4] = post_r[3];
    for (int i = 0; i < 3; i++) begin
      post_nxt[4].prod[i] = 69'($signed(post_r[3].un)) * 69'($signed(post_r[3].nrm[i]));
    end

    // Round to the normal part
    post_nxt[5] = post_r[4];
    for (int i = 0; i < 3; i++) begin
      post_nxt[5].vn[i] = 39'(rnd_sh(72'($signed(post_r[4].prod[i])), 30));
    end

    // Form tangential part, scale both parts by their coefficients
    post_nxt[6] = post_r[5];
    for (int i = 0; i < 3; i++) begin
      vt[i] = 40'($signed(post_r[5].u[i])) - 40'($signed(post_r[5].vn[i]));
      post_nxt[6].rc[i] = 58'($signed(post_r[5].vn[i])) * 58'($signed({1'b0, rsum}));
      post_nxt[6].fc[i] = 59'(vt[i]) * 59'($signed({1'b0, fric_r}));
    end

    // Round both terms; drop reflection unless moving outward
    post_nxt[7] = post_r[6];
    for (int i = 0; i < 3; i++) begin
      post_nxt[7].r1[i] = ($signed(post_r[6].un) > 37'sd0)
                          ? 42'(rnd_sh(72'($signed(post_r[6].rc[i])), 16)) : 42'd0;
      post_nxt[7].r2[i] = 43'(rnd_sh(72'($signed(post_r[6].fc[i])), 16));
    end

    // Subtract, remove the mean, saturate; bypass a zero area vector
    for (int i = 0; i < 3; i++) begin
      vs[i] = 46'($signed(post_r[7].u[i])) - 46'($signed(post_r[7].r1[i]))
              - 46'($signed(post_r[7].r2[i])) - 46'($signed(post_r[7].mean[i]));
      fl[i] = 33'($signed(post_r[7].u[i]) - $signed(post_r[7].mean[i]));
      if (post_r[7].deg) begin
        res_v[i] = fl[i][31:0];
      end else if (vs[i] > SAT_HI) begin
        res_v[i] = SAT_HI[31:0];
      end else if (vs[i] < SAT_LO) begin
        res_v[i] = SAT_LO[31:0];
      end else begin
        res_v[i] = vs[i][31:0];
      end
    end
    out_nxt.new_fluct_vx      = res_v[0];
    out_nxt.new_fluct_vy      = res_v[1];
    out_nxt.new_fluct_vz      = res_v[2];
    out_nxt.degenerate_normal = post_r[7].deg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < POST_N; j++) begin
        post_r[j] <= post_nxt[j];
      end
      out_r <= out_nxt;
    end
  end

  // Quotient magnitudes of the first post stage stay within 1.0
  assign quot_ok = (post_r[0].dq[0] <= 31'h4000_0000) &&
                   (post_r[0].dq[1] <= 31'h4000_0000) &&
                   (post_r[0].dq[2] <= 31'h4000_0000);

  // Normalized magnitude reaches 2^30 for a nonzero area vector
  `PWR_ASSERT_IMPL(a_norm_top, vld_r[ST_SQ - 1] && !sb_w[ST_SQ - 1].deg, sb_w[ST_SQ - 1].mx[31:30] != 2'b00)
  // Root of a normalized length stays in [2^30, 2^32)
  `PWR_ASSERT_IMPL(a_root_range, vld_r[ST_DVI] && !dvi_st_r.deg, dvi_st_r.m[31:30] != 2'b00)
  // Root of a zero vector is zero
  `PWR_ASSERT_IMPL(a_root_zero, vld_r[ST_DVI] && dvi_st_r.deg, dvi_st_r.m == 32'd0)
  // Normal components never exceed 1.0
  `PWR_ASSERT_IMPL(a_quot_bound, vld_r[ST_P0] && !post_r[0].deg, quot_ok)
  // A held result is not lost while the chain stalls
  `PWR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

endmodule
